### hdl/fmam_pkg.sv
// Shared constants, register indexes and the glyph lookup for the frame motion mapper.
package fmam_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;

    localparam int PIXEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ROWS_CFG_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS       = 2'd2;

    localparam logic [7:0]            THRESHOLD_RESET = 8'd20;
    localparam logic [7:0]            WIDTH_RESET     = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET      = 7'd24;

    localparam int GLYPH_COUNT = 19;
    localparam int GLYPH_IDX_W = 5;

    // Dark to light.
    function automatic logic [7:0] glyph_code(input logic [GLYPH_IDX_W-1:0] idx);
        logic [7:0] code;
        unique case (idx)
            5'd0:    code = "@";
            5'd1:    code = "#";
            5'd2:    code = "W";
            5'd3:    code = "$";
            5'd4:    code = "2";
            5'd5:    code = "1";
            5'd6:    code = "a";
            5'd7:    code = "b";
            5'd8:    code = "c";
            5'd9:    code = "?";
            5'd10:   code = "!";
            5'd11:   code = ";";
            5'd12:   code = ":";
            5'd13:   code = "+";
            5'd14:   code = "=";
            5'd15:   code = "-";
            5'd16:   code = ",";
            5'd17:   code = ".";
            default: code = " ";
        endcase
        return code;
    endfunction

endpackage

### hdl/frame_motion_ascii_mapper.sv
// Top level: frame-difference motion detector with brightness-to-glyph mapping.
//
//  channel  | ports                                             | direction
//  ---------+---------------------------------------------------+----------
//  pixels   | s_valid s_ready s_pixel                           | in
//  results  | m_valid m_ready m_glyph m_red_level m_line_end    | out
//           | m_frame_end                                       |
//  config   | cfg_wr_en cfg_index cfg_wdata                     | in
//
// One pixel per cycle sustained while m_ready is high and no clearing pass runs.
// The frame store is one RAM: the pixel is written at its address in the same
// cycle the old value is read (read-first), so consecutive pixels never conflict.
// After reset a clearing pass zeroes all MAX_COLUMNS*MAX_ROWS words of the store
// (8192 by default), with s_ready low; config writes are taken throughout.
// A stalled m_ready holds the output register, then the read stage, then s_ready.
module frame_motion_ascii_mapper #(
    parameter int MAX_COLUMNS = fmam_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = fmam_pkg::MAX_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fmam_pkg::PIXEL_W-1:0]    s_pixel,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_glyph,
    output logic [fmam_pkg::PIXEL_W-1:0]    m_red_level,
    output logic                            m_line_end,
    output logic                            m_frame_end,

    input  logic                            cfg_wr_en,
    input  logic [fmam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmam_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int WW    = CW + 1;
    localparam int HW    = RW + 1;
    localparam int CMPW  = (WW > 8) ? WW : 8;
    localparam int CMPH  = (HW > fmam_pkg::ROWS_CFG_W) ? HW : fmam_pkg::ROWS_CFG_W;
    localparam int PW    = fmam_pkg::PIXEL_W;

    // Configuration registers
    logic [7:0]                      threshold_reg;
    logic [7:0]                      width_reg;
    logic [fmam_pkg::ROWS_CFG_W-1:0] rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= fmam_pkg::THRESHOLD_RESET;
            width_reg     <= fmam_pkg::WIDTH_RESET;
            rows_reg      <= fmam_pkg::ROWS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fmam_pkg::REG_MOTION_THRESHOLD: threshold_reg <= cfg_wdata;
                fmam_pkg::REG_LINE_WIDTH:       width_reg     <= cfg_wdata;
                fmam_pkg::REG_FRAME_ROWS:       rows_reg      <= cfg_wdata[fmam_pkg::ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry, clamped to 1..MAX
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;

    always_comb begin
        if (width_reg == 8'd0) begin
            w_eff = WW'(1);
        end else if (CMPW'(width_reg) > CMPW'(MAX_COLUMNS)) begin
            w_eff = WW'(MAX_COLUMNS);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (rows_reg == '0) begin
            h_eff = HW'(1);
        end else if (CMPH'(rows_reg) > CMPH'(MAX_ROWS)) begin
            h_eff = HW'(MAX_ROWS);
        end else begin
            h_eff = HW'(rows_reg);
        end
        col_last = CW'(w_eff - WW'(1));
        row_last = RW'(h_eff - HW'(1));
    end

    // Raster position
    logic [CW-1:0] col_reg, col_next, col_eff;
    logic [RW-1:0] row_reg, row_next, row_eff;
    logic          is_last_col, is_last_row;
    logic [AW-1:0] pix_addr;

    logic s_xfer;
    logic s1_valid_reg;
    logic s1_advance;
    logic clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    assign s1_advance = !m_valid || m_ready;
    assign s_ready    = !clr_active_reg && (!s1_valid_reg || s1_advance);
    assign s_xfer     = s_valid && s_ready;

    always_comb begin
        // A counter left beyond the edge by a geometry change sits on the edge.
        col_eff     = (col_reg > col_last) ? col_last : col_reg;
        row_eff     = (row_reg > row_last) ? row_last : row_reg;
        is_last_col = (col_eff == col_last);
        is_last_row = (row_eff == row_last);
        pix_addr    = AW'(row_eff) * AW'(w_eff) + AW'(col_eff);
        if (is_last_col) begin
            col_next = '0;
            row_next = is_last_row ? '0 : row_eff + RW'(1);
        end else begin
            col_next = col_eff + CW'(1);
            row_next = row_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_xfer) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Frame store
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [PW-1:0] ram_wr_data;
    logic [PW-1:0] prev_pixel;

    assign ram_wr_en   = clr_active_reg || s_xfer;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : pix_addr;
    assign ram_wr_data = clr_active_reg ? '0 : s_pixel;

    fmam_ram #(
        .DATA_W (PW),
        .DEPTH  (DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s_xfer),
        .rd_addr (pix_addr),
        .rd_data (prev_pixel)
    );

    // Read stage: waits on the RAM output, which holds while stalled
    logic [PW-1:0] s1_pixel_reg;
    logic          s1_line_end_reg;
    logic          s1_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_pixel_reg     <= s_pixel;
            s1_line_end_reg  <= is_last_col;
            s1_frame_end_reg <= is_last_col && is_last_row;
        end
    end

    // Difference and glyph
    logic [PW-1:0]                    diff;
    logic [PW-1:0]                    red_next;
    logic [12:0]                      scaled;
    logic [12:0]                      div_sum;
    logic [fmam_pkg::GLYPH_IDX_W-1:0] glyph_idx;

    always_comb begin
        diff     = (s1_pixel_reg >= prev_pixel) ? s1_pixel_reg - prev_pixel
                                                : prev_pixel - s1_pixel_reg;
        red_next = (diff > threshold_reg) ? diff : '0;
        // x/255 = (x + (x >> 8) + 1) >> 8, exact for x below 65535
        scaled    = 13'(s1_pixel_reg) * 13'(fmam_pkg::GLYPH_COUNT - 1);
        div_sum   = scaled + (scaled >> 8) + 13'd1;
        glyph_idx = div_sum[8 +: fmam_pkg::GLYPH_IDX_W];
    end

    // Output register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_glyph     <= fmam_pkg::glyph_code(glyph_idx);
            m_red_level <= red_next;
            m_line_end  <= s1_line_end_reg;
            m_frame_end <= s1_frame_end_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/fmam_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module fmam_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8192,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Read-first: a same-cycle write to rd_addr returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### dv/frame_motion_ascii_mapper_tb.sv
// Self-checking testbench for the frame motion ASCII mapper: directed corners, then random frames.
`timescale 1ns / 100ps

module frame_motion_ascii_mapper_tb;

    localparam int COLS_MAX = fmam_pkg::MAX_COLUMNS_DEF;
    localparam int ROWS_MAX = fmam_pkg::MAX_ROWS_DEF;
    localparam logic [fmam_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // Dark to light, leftmost character in the top byte.
    localparam logic [8*fmam_pkg::GLYPH_COUNT-1:0] GLYPH_RAMP = "@#W$21abc?!;:+=-,. ";

    typedef struct packed {
        logic [7:0] glyph;
        logic [7:0] red_level;
        logic       line_end;
        logic       frame_end;
    } mapped_px_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [fmam_pkg::PIXEL_W-1:0]    s_pixel = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [7:0]                      m_glyph;
    logic [fmam_pkg::PIXEL_W-1:0]    m_red_level;
    logic                            m_line_end;
    logic                            m_frame_end;
    logic                            cfg_wr_en = 1'b0;
    logic [fmam_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fmam_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the block's state and registers
    logic [7:0]                      store_mirror [COLS_MAX*ROWS_MAX];
    logic [6:0]                      col_cnt;
    logic [5:0]                      row_cnt;
    logic [7:0]                      motion_thr;
    logic [7:0]                      line_width;
    logic [fmam_pkg::ROWS_CFG_W-1:0] frame_rows;

    mapped_px_t  mapped_pending[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    frame_motion_ascii_mapper i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_glyph     (m_glyph),
        .m_red_level (m_red_level),
        .m_line_end  (m_line_end),
        .m_frame_end (m_frame_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned eff_width();
        if (line_width == 0) return 1;
        if (line_width > COLS_MAX) return COLS_MAX;
        return line_width;
    endfunction

    function automatic int unsigned eff_rows();
        if (frame_rows == 0) return 1;
        if (frame_rows > ROWS_MAX) return ROWS_MAX;
        return frame_rows;
    endfunction

    function automatic int unsigned cursor_addr();
        int unsigned w, col, row;
        w   = eff_width();
        col = (col_cnt > w - 1) ? w - 1 : col_cnt;
        row = (row_cnt > eff_rows() - 1) ? eff_rows() - 1 : row_cnt;
        return row * w + col;
    endfunction

    // Expected result of one pixel; advances the mirrored store and counters.
    function automatic mapped_px_t map_pixel(input logic [7:0] px);
        mapped_px_t  res;
        int unsigned w, h, col, row, addr, pv, old, diff, gi;
        w    = eff_width();
        h    = eff_rows();
        col  = (col_cnt > w - 1) ? w - 1 : col_cnt;
        row  = (row_cnt > h - 1) ? h - 1 : row_cnt;
        addr = cursor_addr();
        pv   = px;
        old  = store_mirror[addr];
        diff = (pv >= old) ? pv - old : old - pv;
        gi   = (pv * (fmam_pkg::GLYPH_COUNT - 1)) / 255;
        res.glyph     = GLYPH_RAMP[8*(fmam_pkg::GLYPH_COUNT-1-gi) +: 8];
        res.red_level = (diff > motion_thr) ? 8'(diff) : 8'd0;
        res.line_end  = (col == w - 1);
        res.frame_end = res.line_end && (row == h - 1);
        store_mirror[addr] = px;
        if (res.line_end) begin
            col_cnt = '0;
            row_cnt = (row == h - 1) ? 6'd0 : 6'(row + 1);
        end else begin
            col_cnt = 7'(col + 1);
            row_cnt = 6'(row);
        end
        return res;
    endfunction

    always @(posedge aclk) begin : check_results
        mapped_px_t want;
        if (aresetn && m_valid && m_ready) begin
            if (mapped_pending.size() == 0) begin
                report_mismatch("result transfer with no pixel pending");
            end else begin
                want = mapped_pending.pop_front();
                if (m_glyph !== want.glyph)
                    report_mismatch($sformatf("glyph %h, want %h", m_glyph, want.glyph));
                if (m_red_level !== want.red_level)
                    report_mismatch($sformatf("red_level %0d, want %0d",
                                              m_red_level, want.red_level));
                if (m_line_end !== want.line_end)
                    report_mismatch($sformatf("line_end %b, want %b", m_line_end, want.line_end));
                if (m_frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              m_frame_end, want.frame_end));
            end
        end
    end

    task automatic send_pixel(input logic [7:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        mapped_pending.push_back(map_pixel(px));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (mapped_pending.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [fmam_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            fmam_pkg::REG_MOTION_THRESHOLD: motion_thr = val;
            fmam_pkg::REG_LINE_WIDTH:       line_width = val;
            fmam_pkg::REG_FRAME_ROWS:       frame_rows = val[fmam_pkg::ROWS_CFG_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        // threshold 20 against a cleared store; glyph bucket edges at 14/15
        logic [7:0] px_list [8] = '{8'd0, 8'd20, 8'd21, 8'd255, 8'd14, 8'd15, 8'd240, 8'd128};
        foreach (px_list[i]) send_pixel(px_list[i]);
        wait_drained();
    endtask

    task automatic test_mid_frame_geometry();
        // column counter sits past the new last column
        write_reg(fmam_pkg::REG_LINE_WIDTH, 8'd4);
        send_pixel(8'd200);
        send_pixel(8'd1);
        wait_drained();
        write_reg(fmam_pkg::REG_FRAME_ROWS, 8'd1);
        send_pixel(8'd77);
        wait_drained();
        write_reg(fmam_pkg::REG_LINE_WIDTH, 8'd0);
        write_reg(fmam_pkg::REG_FRAME_ROWS, 8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        wait_drained();
    endtask

    task automatic test_oversize_geometry();
        write_reg(fmam_pkg::REG_LINE_WIDTH, 8'd255);
        write_reg(fmam_pkg::REG_FRAME_ROWS, 8'hFF);
        send_pixel(8'd90);
        send_pixel(8'd10);
        wait_drained();
        // top bit of the rows write is dropped, leaving zero
        write_reg(fmam_pkg::REG_FRAME_ROWS, 8'h80);
        send_pixel(8'd33);
        wait_drained();
        write_reg(fmam_pkg::REG_LINE_WIDTH, 8'd128);
        write_reg(fmam_pkg::REG_FRAME_ROWS, 8'd64);
        send_pixel(8'd170);
        wait_drained();
    endtask

    task automatic test_unknown_register();
        write_reg(REG_UNUSED, 8'h00);
        send_pixel(8'd60);
        send_pixel(8'd5);
        wait_drained();
    endtask

    task automatic test_threshold_extremes();
        write_reg(fmam_pkg::REG_LINE_WIDTH, 8'd2);
        write_reg(fmam_pkg::REG_FRAME_ROWS, 8'd1);
        write_reg(fmam_pkg::REG_MOTION_THRESHOLD, 8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd255);
        wait_drained();
        write_reg(fmam_pkg::REG_MOTION_THRESHOLD, 8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        wait_drained();
        write_reg(fmam_pkg::REG_MOTION_THRESHOLD, 8'd254);
        send_pixel(8'd0);
        send_pixel(8'd255);
        wait_drained();
    endtask

    function automatic logic [7:0] stim_pixel();
        int old, delta, v;
        old = store_mirror[cursor_addr()];
        case ($urandom_range(9))
            0, 1: return 8'($urandom);
            2:    return $urandom_range(1) ? 8'hFF : 8'h00;
            3, 4: delta = int'(motion_thr) + int'($urandom_range(2)) - 1;   // near threshold
            default: delta = $urandom_range((motion_thr > 200) ? 255 : motion_thr + 30);
        endcase
        v = $urandom_range(1) ? old + delta : old - delta;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic pick_settings();
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(5))
                0:       write_reg(fmam_pkg::REG_MOTION_THRESHOLD, 8'd0);
                1:       write_reg(fmam_pkg::REG_MOTION_THRESHOLD, 8'd255);
                2:       write_reg(fmam_pkg::REG_MOTION_THRESHOLD, 8'($urandom));
                default: write_reg(fmam_pkg::REG_MOTION_THRESHOLD, 8'($urandom_range(40)));
            endcase
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
                0:       write_reg(fmam_pkg::REG_LINE_WIDTH, 8'd0);
                1:       write_reg(fmam_pkg::REG_LINE_WIDTH, 8'd128);
                2:       write_reg(fmam_pkg::REG_LINE_WIDTH, 8'($urandom_range(255, 129)));
                default: write_reg(fmam_pkg::REG_LINE_WIDTH, 8'($urandom_range(8, 1)));
            endcase
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
                0:       write_reg(fmam_pkg::REG_FRAME_ROWS, 8'd0);
                1:       write_reg(fmam_pkg::REG_FRAME_ROWS, 8'd64);
                2:       write_reg(fmam_pkg::REG_FRAME_ROWS, 8'($urandom));
                default: write_reg(fmam_pkg::REG_FRAME_ROWS, 8'($urandom_range(4, 1)));
            endcase
        end
        if ($urandom_range(9) == 0) write_reg(REG_UNUSED, 8'($urandom));
    endtask

    task automatic run_random_frames(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
        int unsigned sent, seg_len, frame_px;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            wait_drained();
            pick_settings();
            frame_px = eff_width() * eff_rows();
            if (frame_px > 48) seg_len = $urandom_range(48, 8);
            else seg_len = frame_px * $urandom_range(4, 2);
            // sometimes stop partway into a frame
            if ($urandom_range(3) == 0)
                seg_len += $urandom_range((frame_px > 8) ? 8 : frame_px, 1);
            if (seg_len > n_items - sent) seg_len = n_items - sent;
            repeat (seg_len) begin
                send_pixel(stim_pixel());
                sent++;
                if ($urandom_range(49) == 0) wait_drained();
            end
        end
        wait_drained();
    endtask

    task automatic finish_run();
        int unsigned guard;
        guard = 0;
        s_valid <= 1'b0;
        while (mapped_pending.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (mapped_pending.size() != 0)
            report_mismatch($sformatf("%0d pixels never produced a result",
                                      mapped_pending.size()));
    endtask

    initial begin
        foreach (store_mirror[i]) store_mirror[i] = 8'd0;
        col_cnt    = '0;
        row_cnt    = '0;
        motion_thr = fmam_pkg::THRESHOLD_RESET;
        line_width = fmam_pkg::WIDTH_RESET;
        frame_rows = fmam_pkg::ROWS_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_mid_frame_geometry();
        test_oversize_geometry();
        test_unknown_register();
        test_threshold_extremes();
        run_random_frames(0, 0, 155);
        run_random_frames(53, 0, 155);
        run_random_frames(0, 53, 155);
        run_random_frames(29, 29, 155);
        finish_run();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
